@@ hdl/mhpq_pkg.sv @@
// Shared types and constants for the binary max-heap priority queue.
// Depends on nothing; the top level, checker and bench refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHD_W    = IDX_W + 1;
  localparam int ENTRY_W  = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_LOAD,
    S_UP,
    S_DOWN,
    S_DONE
  } state_t;

endpackage : mhpq_pkg

`default_nettype wire

@@ hdl/mhpq_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
// Depends on nothing; holds the heap entries for the top level.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wa,
  input  wire logic [WIDTH-1:0] wd,
  input  wire logic [AW-1:0]    ra_addr,
  input  wire logic [AW-1:0]    rb_addr,
  output logic      [WIDTH-1:0] rd_a,
  output logic      [WIDTH-1:0] rd_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_a <= mem[ra_addr];
    rd_b <= mem[rb_addr];
  end

endmodule : mhpq_ram

`default_nettype wire

@@ hdl/max_heap_priority_queue_unit.sv @@
// Top level of the binary max-heap priority queue: command FSM, sift logic.
// Depends on mhpq_pkg and mhpq_ram.
//
//   channel | ports                                  | beat taken when
//   --------+----------------------------------------+------------------------
//   command | start, busy, in_cmd, in_key_value      | start && !busy
//   result  | out_valid, out_removed_value,          | every cycle out_valid
//           | out_top_value, out_top_valid,          | is high (one cycle)
//           | out_entry_count, out_status            |
//
// One command at a time. Each sift level is one read, compare and write back on the heap
// RAM; pop and delete pass through S_LOAD to fetch the last entry when it must fill a gap,
// and every command ends in S_DONE for the result beat. Delete first scans the entries in
// order in S_SEARCH, then sifts the moved entry up or down. Rejects go straight to S_DONE.
// Reset clears the count and the FSM; heap RAM contents are not cleared.
// The result beat cannot be stalled; busy stays high until it is shown.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic signed [31:0] in_key_value,
  output logic             out_valid,
  output logic signed [31:0] out_removed_value,
  output logic signed [31:0] out_top_value,
  output logic             out_top_valid,
  output logic [6:0]       out_entry_count,
  output logic [1:0]       out_status
);

  localparam int IDX_W = mhpq_pkg::IDX_W;
  localparam int CNT_W = mhpq_pkg::CNT_W;
  localparam int CHD_W = mhpq_pkg::CHD_W;
  localparam int KEY_W = mhpq_pkg::KEY_W;

  mhpq_pkg::state_t  state_r, state_nxt;
  mhpq_pkg::status_t status_r, status_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        hole_r, hole_nxt;
  logic [IDX_W-1:0]        sidx_r, sidx_nxt;
  logic signed [KEY_W-1:0] val_r, val_nxt;
  logic signed [KEY_W-1:0] top_r;
  logic signed [KEY_W-1:0] removed_r, removed_nxt;
  logic                    del_r, del_nxt;
  logic                    moved_r, moved_nxt;

  logic             we;
  logic [IDX_W-1:0] wa;
  logic [KEY_W-1:0] wd;
  logic [IDX_W-1:0] ra_addr, rb_addr;
  logic [KEY_W-1:0] rd_a, rd_b;

  mhpq_ram #(
    .DEPTH (mhpq_pkg::CAPACITY),
    .WIDTH (KEY_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wa      (wa),
    .wd      (wd),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .rd_a    (rd_a),
    .rd_b    (rd_b)
  );

  // Index arithmetic around the hole.
  logic [IDX_W-1:0] hole_m1, parent_w, parent_m1, grand_w;
  logic [IDX_W-1:0] ins_m1, ins_par;
  logic [CHD_W-1:0] l_w, r_w, cnt_x, c_w, c_l, c_r;
  logic [CNT_W-1:0] cnt_dec, sidx_inc;
  logic             l_ok, r_ok, go_l, go_r, up_move, hit;
  logic signed [KEY_W-1:0] bigv;

  always_comb begin
    hole_m1   = hole_r - IDX_W'(1);
    parent_w  = hole_m1 >> 1;
    parent_m1 = parent_w - IDX_W'(1);
    grand_w   = parent_m1 >> 1;
    ins_m1    = cnt_r[IDX_W-1:0] - IDX_W'(1);
    ins_par   = ins_m1 >> 1;
    l_w       = {hole_r, 1'b1};
    r_w       = l_w + CHD_W'(1);
    cnt_x     = CHD_W'(cnt_r);
    l_ok      = l_w < cnt_x;
    r_ok      = r_w < cnt_x;
    go_l      = l_ok && (val_r < $signed(rd_a));
    bigv      = go_l ? $signed(rd_a) : val_r;
    go_r      = r_ok && (bigv < $signed(rd_b));
    c_w       = go_r ? r_w : l_w;
    c_l       = {c_w[IDX_W-1:0], 1'b1};
    c_r       = c_l + CHD_W'(1);
    up_move   = $signed(rd_a) < val_r;
    cnt_dec   = cnt_r - CNT_W'(1);
    sidx_inc  = CNT_W'(sidx_r) + CNT_W'(1);
    hit       = rd_a == val_r;
  end

  always_comb begin
    state_nxt   = state_r;
    status_nxt  = status_r;
    cnt_nxt     = cnt_r;
    hole_nxt    = hole_r;
    sidx_nxt    = sidx_r;
    val_nxt     = val_r;
    removed_nxt = removed_r;
    del_nxt     = del_r;
    moved_nxt   = moved_r;
    we          = 1'b0;
    wa          = hole_r;
    wd          = val_r;
    ra_addr     = parent_w;
    rb_addr     = r_w[IDX_W-1:0];

    unique case (state_r)
      mhpq_pkg::S_IDLE: begin
        if (start) begin
          removed_nxt = '0;
          status_nxt  = mhpq_pkg::ST_OK;
          del_nxt     = 1'b0;
          moved_nxt   = 1'b0;
          val_nxt     = in_key_value;
          unique case (in_cmd)
            mhpq_pkg::CMD_INSERT: begin
              if (cnt_r == CNT_W'(mhpq_pkg::CAPACITY)) begin
                status_nxt = mhpq_pkg::ST_FULL;
                state_nxt  = mhpq_pkg::S_DONE;
              end else begin
                cnt_nxt   = cnt_r + CNT_W'(1);
                hole_nxt  = cnt_r[IDX_W-1:0];
                ra_addr   = ins_par;
                state_nxt = mhpq_pkg::S_UP;
              end
            end
            mhpq_pkg::CMD_POP: begin
              if (cnt_r == '0) begin
                status_nxt = mhpq_pkg::ST_EMPTY;
                state_nxt  = mhpq_pkg::S_DONE;
              end else begin
                removed_nxt = top_r;
                cnt_nxt     = cnt_dec;
                hole_nxt    = '0;
                ra_addr     = cnt_dec[IDX_W-1:0];
                state_nxt   = (cnt_dec == '0) ? mhpq_pkg::S_DONE : mhpq_pkg::S_LOAD;
              end
            end
            mhpq_pkg::CMD_DELETE: begin
              if (cnt_r == '0) begin
                status_nxt = mhpq_pkg::ST_NOTFOUND;
                state_nxt  = mhpq_pkg::S_DONE;
              end else begin
                ra_addr   = '0;
                sidx_nxt  = '0;
                state_nxt = mhpq_pkg::S_SEARCH;
              end
            end
            default: begin
              state_nxt = mhpq_pkg::S_DONE;
            end
          endcase
        end
      end

      mhpq_pkg::S_SEARCH: begin
        ra_addr = sidx_inc[IDX_W-1:0];
        if (hit) begin
          cnt_nxt = cnt_dec;
          if (CNT_W'(sidx_r) == cnt_dec) begin
            state_nxt = mhpq_pkg::S_DONE;
          end else begin
            // fetch the last entry to fill the gap
            ra_addr   = cnt_dec[IDX_W-1:0];
            hole_nxt  = sidx_r;
            del_nxt   = 1'b1;
            state_nxt = mhpq_pkg::S_LOAD;
          end
        end else if (sidx_inc == cnt_r) begin
          status_nxt = mhpq_pkg::ST_NOTFOUND;
          state_nxt  = mhpq_pkg::S_DONE;
        end else begin
          sidx_nxt = sidx_inc[IDX_W-1:0];
        end
      end

      mhpq_pkg::S_LOAD: begin
        val_nxt = $signed(rd_a);
        if (del_r) begin
          ra_addr   = parent_w;
          state_nxt = mhpq_pkg::S_UP;
        end else begin
          ra_addr   = l_w[IDX_W-1:0];
          rb_addr   = r_w[IDX_W-1:0];
          state_nxt = mhpq_pkg::S_DOWN;
        end
      end

      mhpq_pkg::S_UP: begin
        if (hole_r != '0 && up_move) begin
          // pull the parent down into the hole, climb one level
          we        = 1'b1;
          wd        = rd_a;
          hole_nxt  = parent_w;
          moved_nxt = 1'b1;
          ra_addr   = grand_w;
        end else begin
          we = 1'b1;
          if (del_r && !moved_r) begin
            ra_addr   = l_w[IDX_W-1:0];
            rb_addr   = r_w[IDX_W-1:0];
            state_nxt = mhpq_pkg::S_DOWN;
          end else begin
            state_nxt = mhpq_pkg::S_DONE;
          end
        end
      end

      mhpq_pkg::S_DOWN: begin
        we = 1'b1;
        if (go_l || go_r) begin
          // lift the larger child into the hole, descend one level
          wd       = go_r ? rd_b : rd_a;
          hole_nxt = c_w[IDX_W-1:0];
          ra_addr  = c_l[IDX_W-1:0];
          rb_addr  = c_r[IDX_W-1:0];
        end else begin
          state_nxt = mhpq_pkg::S_DONE;
        end
      end

      mhpq_pkg::S_DONE: begin
        state_nxt = mhpq_pkg::S_IDLE;
      end

      default: begin
        state_nxt = mhpq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhpq_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    hole_r    <= hole_nxt;
    sidx_r    <= sidx_nxt;
    val_r     <= val_nxt;
    removed_r <= removed_nxt;
    del_r     <= del_nxt;
    moved_r   <= moved_nxt;
    // mirror the root so the result beat needs no extra read
    if (we && wa == '0) begin
      top_r <= $signed(wd);
    end
  end

  assign busy              = state_r != mhpq_pkg::S_IDLE;
  assign out_valid         = state_r == mhpq_pkg::S_DONE;
  assign out_removed_value = removed_r;
  assign out_top_valid     = cnt_r != '0;
  assign out_top_value     = out_top_valid ? top_r : '0;
  assign out_entry_count   = mhpq_pkg::ENTRY_W'(cnt_r);
  assign out_status        = status_r;

endmodule : max_heap_priority_queue_unit

`default_nettype wire

@@ hdl/mhpq_chk.sv @@
// Port-level checker for the max-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and max_heap_priority_queue_unit.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic signed [31:0] out_top_value,
  input wire logic        out_top_valid,
  input wire logic [6:0]  out_entry_count,
  input wire logic [1:0]  out_status
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low after a command beat was taken");

  a_top_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_top_valid == (out_entry_count != 7'd0))
    else $error("top_valid disagrees with entry count");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_top_valid |-> out_top_value == 32'sd0)
    else $error("top value not zero on an empty heap");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mhpq_pkg::ST_FULL
      |-> out_entry_count == 7'(mhpq_pkg::CAPACITY))
    else $error("full reported below capacity");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= 7'(mhpq_pkg::CAPACITY))
    else $error("entry count above capacity");

endmodule : mhpq_chk

bind max_heap_priority_queue_unit mhpq_chk u_mhpq_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_top_value   (out_top_value),
  .out_top_valid   (out_top_valid),
  .out_entry_count (out_entry_count),
  .out_status      (out_status)
);

`default_nettype wire

@@ tb/tb_max_heap_priority_queue_unit.sv @@
// Self-checking bench for max_heap_priority_queue_unit: directed table, then random
// fill/drain/mixed phases. Each result is checked against its typed table row or a model of the heap kept here.
// Depends on mhpq_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_max_heap_priority_queue_unit;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [31:0] KMIN = 32'sh8000_0000;
  localparam logic signed [31:0] KMAX = 32'sh7FFF_FFFF;
  localparam int RANDOM_ITEMS = 1425;
  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_CYCLES = 20;
  localparam int N_DIR = 25;

  typedef struct packed {
    logic signed [31:0] removed;
    logic signed [31:0] top;
    logic               top_valid;
    logic [6:0]         count;
    mhpq_pkg::status_t  status;
  } heap_result_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
    bit                 typed;
    heap_result_t       want;
  } dir_row_t;

  localparam heap_result_t FROM_MODEL = '{32'sd0, 32'sd0, 1'b0, 7'd0, mhpq_pkg::ST_OK};

  // Rows with typed = 1 carry their expected result in the table; the others take it from the model.
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{mhpq_pkg::CMD_POP,    32'sd0,     1'b1,
      '{32'sd0, 32'sd0, 1'b0, 7'd0, mhpq_pkg::ST_EMPTY}},
    '{mhpq_pkg::CMD_DELETE, 32'sd5,     1'b1,
      '{32'sd0, 32'sd0, 1'b0, 7'd0, mhpq_pkg::ST_NOTFOUND}},
    '{CMD_UNUSED,           32'sd7,     1'b1,
      '{32'sd0, 32'sd0, 1'b0, 7'd0, mhpq_pkg::ST_OK}},
    '{mhpq_pkg::CMD_INSERT, KMIN,       1'b1,
      '{32'sd0, KMIN, 1'b1, 7'd1, mhpq_pkg::ST_OK}},
    '{mhpq_pkg::CMD_INSERT, KMAX,       1'b1,
      '{32'sd0, KMAX, 1'b1, 7'd2, mhpq_pkg::ST_OK}},
    '{mhpq_pkg::CMD_INSERT, 32'sd0,     1'b1,
      '{32'sd0, KMAX, 1'b1, 7'd3, mhpq_pkg::ST_OK}},
    '{mhpq_pkg::CMD_INSERT, -32'sd1,    1'b1,
      '{32'sd0, KMAX, 1'b1, 7'd4, mhpq_pkg::ST_OK}},
    '{mhpq_pkg::CMD_INSERT, 32'sd0,     1'b1,
      '{32'sd0, KMAX, 1'b1, 7'd5, mhpq_pkg::ST_OK}},
    '{mhpq_pkg::CMD_DELETE, 32'sd0,     1'b0, FROM_MODEL},
    '{mhpq_pkg::CMD_DELETE, 32'sd12345, 1'b1,
      '{32'sd0, KMAX, 1'b1, 7'd4, mhpq_pkg::ST_NOTFOUND}},
    '{CMD_UNUSED,           -32'sd1,    1'b1,
      '{32'sd0, KMAX, 1'b1, 7'd4, mhpq_pkg::ST_OK}},
    '{mhpq_pkg::CMD_POP,    32'sd9,     1'b0, FROM_MODEL},
    '{mhpq_pkg::CMD_DELETE, KMIN,       1'b0, FROM_MODEL},
    '{mhpq_pkg::CMD_INSERT, 32'sh4000_0000, 1'b0, FROM_MODEL},
    '{mhpq_pkg::CMD_INSERT, 32'sh4000_0000, 1'b0, FROM_MODEL},
    '{mhpq_pkg::CMD_INSERT, 32'shAAAA_AAAA, 1'b0, FROM_MODEL},
    '{mhpq_pkg::CMD_INSERT, 32'sh5555_5555, 1'b0, FROM_MODEL},
    '{mhpq_pkg::CMD_DELETE, 32'sh5555_5555, 1'b0, FROM_MODEL},
    '{mhpq_pkg::CMD_POP,    KMAX,       1'b0, FROM_MODEL},
    '{mhpq_pkg::CMD_POP,    KMIN,       1'b0, FROM_MODEL},
    '{mhpq_pkg::CMD_POP,    32'sd0,     1'b0, FROM_MODEL},
    '{mhpq_pkg::CMD_POP,    32'sd0,     1'b0, FROM_MODEL},
    '{mhpq_pkg::CMD_POP,    32'sd0,     1'b0, FROM_MODEL},
    '{mhpq_pkg::CMD_POP,    32'sd0,     1'b1,
      '{32'sd0, 32'sd0, 1'b0, 7'd0, mhpq_pkg::ST_EMPTY}},
    '{mhpq_pkg::CMD_DELETE, -32'sd1,    1'b1,
      '{32'sd0, 32'sd0, 1'b0, 7'd0, mhpq_pkg::ST_NOTFOUND}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_cmd = 2'd0;
  logic signed [31:0] in_key_value = 32'sd0;
  logic busy;
  logic out_valid;
  logic signed [31:0] out_removed_value;
  logic signed [31:0] out_top_value;
  logic out_top_valid;
  logic [6:0] out_entry_count;
  logic [1:0] out_status;

  // Heap model state
  logic signed [31:0] heap_keys [mhpq_pkg::CAPACITY];
  int heap_fill = 0;
  int peak_fill = 0;

  heap_result_t pending_results[$];
  int err_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int full_seen = 0;
  int empty_seen = 0;
  int notfound_seen = 0;
  bit no_idle = 1'b0;

  max_heap_priority_queue_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_key_value      (in_key_value),
    .out_valid         (out_valid),
    .out_removed_value (out_removed_value),
    .out_top_value     (out_top_value),
    .out_top_valid     (out_top_valid),
    .out_entry_count   (out_entry_count),
    .out_status        (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles, %0d results pending", $realtime,
               cycle_count, pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
    err_count++;
  endtask

  function automatic void swap_keys(input int a, input int b);
    logic signed [31:0] t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  // Climb only past a strictly smaller parent.
  function automatic void sift_key_up(input int idx);
    int i;
    int p;
    i = idx;
    while (i != 0) begin
      p = (i - 1) / 2;
      if (!(heap_keys[p] < heap_keys[i])) break;
      swap_keys(i, p);
      i = p;
    end
  endfunction

  // Descend only to a strictly larger child; left wins a tie.
  function automatic void sift_key_down(input int idx);
    int i;
    int big;
    int l;
    int r;
    i = idx;
    forever begin
      big = i;
      l = 2 * i + 1;
      r = 2 * i + 2;
      if (l < heap_fill && heap_keys[big] < heap_keys[l]) big = l;
      if (r < heap_fill && heap_keys[big] < heap_keys[r]) big = r;
      if (big == i) break;
      swap_keys(i, big);
      i = big;
    end
  endfunction

  function automatic heap_result_t apply_heap_cmd(input logic [1:0] op,
                                                  input logic signed [31:0] key);
    heap_result_t res;
    int slot;
    bit hit;
    res.removed = 32'sd0;
    res.status = mhpq_pkg::ST_OK;
    hit = 1'b0;
    case (op)
      mhpq_pkg::CMD_INSERT: begin
        if (heap_fill >= mhpq_pkg::CAPACITY) begin
          res.status = mhpq_pkg::ST_FULL;
        end else begin
          heap_keys[heap_fill] = key;
          heap_fill++;
          sift_key_up(heap_fill - 1);
        end
      end
      mhpq_pkg::CMD_POP: begin
        if (heap_fill == 0) begin
          res.status = mhpq_pkg::ST_EMPTY;
        end else begin
          res.removed = heap_keys[0];
          heap_fill--;
          if (heap_fill != 0) begin
            heap_keys[0] = heap_keys[heap_fill];
            sift_key_down(0);
          end
        end
      end
      mhpq_pkg::CMD_DELETE: begin
        for (slot = 0; slot < heap_fill; slot++) begin
          if (heap_keys[slot] == key) begin
            hit = 1'b1;
            break;
          end
        end
        if (!hit) begin
          res.status = mhpq_pkg::ST_NOTFOUND;
        end else begin
          heap_fill--;
          // Removing the last slot needs no reordering.
          if (slot < heap_fill) begin
            heap_keys[slot] = heap_keys[heap_fill];
            sift_key_up(slot);
            sift_key_down(slot);
          end
        end
      end
      default: ;
    endcase
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    res.top = (heap_fill != 0) ? heap_keys[0] : 32'sd0;
    res.top_valid = (heap_fill != 0);
    res.count = 7'(heap_fill);
    return res;
  endfunction

  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] k;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: k = KMIN;
          1: k = KMAX;
          2: k = 32'sd0;
          3: k = -32'sd1;
          4: k = KMIN + 32'sd1;
          default: k = KMAX - 32'sd1;
        endcase
      end
      1, 2, 3, 4: begin
        // Narrow range: plenty of duplicates and delete hits.
        k = $urandom_range(0, 16);
        k = k - 32'sd8;
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  task automatic issue_cmd(input logic [1:0] op, input logic signed [31:0] key,
                           input bit typed, input heap_result_t want);
    int gap;
    heap_result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= op;
    in_key_value <= key;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_heap_cmd(op, key);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  always @(posedge clk) begin : result_check
    heap_result_t want_r;
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      case (out_status)
        mhpq_pkg::ST_FULL: full_seen++;
        mhpq_pkg::ST_EMPTY: empty_seen++;
        mhpq_pkg::ST_NOTFOUND: notfound_seen++;
        default: ;
      endcase
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no command outstanding");
      end else begin
        want_r = pending_results.pop_front();
        if (out_removed_value !== want_r.removed)
          report_mismatch($sformatf("removed_value got %0d want %0d",
                                    out_removed_value, want_r.removed));
        if (out_top_value !== want_r.top)
          report_mismatch($sformatf("top_value got %0d want %0d",
                                    out_top_value, want_r.top));
        if (out_top_valid !== want_r.top_valid)
          report_mismatch($sformatf("top_valid got %b want %b",
                                    out_top_valid, want_r.top_valid));
        if (out_entry_count !== want_r.count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    out_entry_count, want_r.count));
        if (out_status !== want_r.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_status, want_r.status));
      end
    end
  end

  initial begin
    int row;
    int rand_items;
    int mode;
    int phase_len;
    int n;
    int r;
    logic [1:0] op;
    logic signed [31:0] key;
    rand_items = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < N_DIR; row++) begin
      issue_cmd(DIR_ROWS[row].op, DIR_ROWS[row].key, DIR_ROWS[row].typed,
                DIR_ROWS[row].want);
    end

    // Phases: mode 0 fills toward full, mode 1 drains toward empty, mode 2 mixes.
    while (rand_items < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      no_idle = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 120);
      for (n = 0; n < phase_len && rand_items < RANDOM_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0: op = (r < 85) ? mhpq_pkg::CMD_INSERT : (r < 92) ? mhpq_pkg::CMD_POP :
                  (r < 98) ? mhpq_pkg::CMD_DELETE : CMD_UNUSED;
          1: op = (r < 65) ? mhpq_pkg::CMD_POP : (r < 90) ? mhpq_pkg::CMD_DELETE :
                  (r < 95) ? mhpq_pkg::CMD_INSERT : CMD_UNUSED;
          default: op = (r < 45) ? mhpq_pkg::CMD_INSERT : (r < 70) ? mhpq_pkg::CMD_POP :
                        (r < 97) ? mhpq_pkg::CMD_DELETE : CMD_UNUSED;
        endcase
        // Most deletes target a key that is present.
        if (op == mhpq_pkg::CMD_DELETE && heap_fill > 0 && $urandom_range(0, 3) != 0)
          key = heap_keys[$urandom_range(0, heap_fill - 1)];
        else
          key = pick_key();
        issue_cmd(op, key, 1'b0, FROM_MODEL);
        rand_items++;
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands, %0d results; peak fill %0d of %0d.",
             items_sent, results_seen, peak_fill, mhpq_pkg::CAPACITY);
    $display("Full on insert %0d, empty on pop %0d, key not found %0d.",
             full_seen, empty_seen, notfound_seen);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
